### rtl/assert_macros.svh
// Concurrent assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/e2r_pkg.sv
`default_nettype none

package e2r_pkg;

	localparam int ANGLE_BITS_DEF = 12;
	localparam int ANGLE_W = 16;
	localparam int AXIS_W = 16;
	localparam int SCALE_W = 16;
	localparam logic [SCALE_W-1:0] AXIS_SCALE_RESET = 16'd3277;

	typedef struct packed {
		logic [ANGLE_W-1:0] pitch_angle;
		logic [ANGLE_W-1:0] yaw_angle;
		logic [ANGLE_W-1:0] roll_angle;
	} angles_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] right_axis_x;
		logic signed [AXIS_W-1:0] right_axis_y;
		logic signed [AXIS_W-1:0] right_axis_z;
		logic signed [AXIS_W-1:0] up_axis_x;
		logic signed [AXIS_W-1:0] up_axis_y;
		logic signed [AXIS_W-1:0] up_axis_z;
		logic signed [AXIS_W-1:0] forward_axis_x;
		logic signed [AXIS_W-1:0] forward_axis_y;
		logic signed [AXIS_W-1:0] forward_axis_z;
	} axes_t;

endpackage

`default_nettype wire

### rtl/e2r_stream_if.sv
`default_nettype none

interface e2r_stream_if #(
	parameter type data_t = logic
) ();
	logic valid;
	logic ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/e2r_sincos.sv
`default_nettype none

module e2r_sincos #(
	parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic [e2r_pkg::ANGLE_W-1:0] angle,
	output logic signed [e2r_pkg::AXIS_W-1:0] sin_val,
	output logic signed [e2r_pkg::AXIS_W-1:0] cos_val
);
	import e2r_pkg::*;

	localparam int QUARTER = 2 ** (ANGLE_BITS - 2);
	localparam int ADDR_W = ANGLE_BITS - 1;
	localparam int MAG_W = AXIS_W - 1;
	localparam real HALF_PI = 1.5707963267948966;
	localparam real SINE_AMP = 32767.0;

	typedef logic [MAG_W-1:0] qtab_t [QUARTER+1];

	function automatic qtab_t build_qtab();
		qtab_t t;
		real x;
		for (int m = 0; m <= QUARTER; m++) begin
			x = SINE_AMP * $sin(HALF_PI * real'(m) / QUARTER);
			t[m] = MAG_W'($rtoi(x + 0.5));
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();
	localparam logic [ADDR_W-1:0] QUARTER_A = ADDR_W'(QUARTER);

	logic [ANGLE_BITS-1:0] k;
	logic [1:0] quad;
	logic [ADDR_W-1:0] r_ext;
	logic [ADDR_W-1:0] r_flip;
	logic [ADDR_W-1:0] sin_addr;
	logic [ADDR_W-1:0] cos_addr;

	logic [MAG_W-1:0] sin_mag_s1;
	logic [MAG_W-1:0] cos_mag_s1;
	logic sin_neg_s1;
	logic cos_neg_s1;

	always_comb begin
		k = angle[ANGLE_W-1 -: ANGLE_BITS];
		quad = k[ANGLE_BITS-1 -: 2];
		r_ext = {1'b0, k[ANGLE_BITS-3:0]};
		r_flip = QUARTER_A - r_ext;
		sin_addr = quad[0] ? r_flip : r_ext;
		cos_addr = quad[0] ? r_ext : r_flip;
	end

	// quarter-wave ROM, two registered read ports
	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag_s1 <= QTAB[sin_addr];
			cos_mag_s1 <= QTAB[cos_addr];
			sin_neg_s1 <= quad[1];
			cos_neg_s1 <= quad[1] ^ quad[0];
		end
	end

	assign sin_val = sin_neg_s1 ? -$signed({1'b0, sin_mag_s1}) : $signed({1'b0, sin_mag_s1});
	assign cos_val = cos_neg_s1 ? -$signed({1'b0, cos_mag_s1}) : $signed({1'b0, cos_mag_s1});

endmodule

`default_nettype wire

### rtl/euler_to_rotation_axes.sv
// Euler angles to rotation axes.
// angles (sink): pitch, yaw and roll as 16-bit binary angles, 65536 per turn.
// axes (source): right (negated), up and forward axes, nine Q1.15 values, each
// scaled by axis_scale (Q0.16) and clamped to +-32767.
// cfg_wr_en / cfg_wr_data write axis_scale; write it only while the block is idle.
// A transaction is taken at a rising edge with valid and ready both high.
// Five register stages: quarter-wave sine ROM read, first products, second
// products, sum and scale product, shift and clamp into the output register.
// One transaction per cycle is sustained while axes.ready stays high, as the
// multiplier stages are fully pipelined.
// When axes.ready is low, stages behind the output keep filling until full;
// angles.ready falls only when every stage holds an item. Nothing is dropped.
// arst_n clears all valid bits and sets axis_scale to 3277 (0.05).
`default_nettype none
`include "assert_macros.svh"

module euler_to_rotation_axes #(
	parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic [e2r_pkg::SCALE_W-1:0] cfg_wr_data,
	e2r_stream_if.sink angles,
	e2r_stream_if.source axes
);
	import e2r_pkg::*;

	localparam int NUM_AXES = 9;
	localparam int SUM_W = AXIS_W + 2;
	localparam int PROD_W = SUM_W + SCALE_W + 1;
	localparam int SHIFT_W = PROD_W - SCALE_W;
	localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'(32767);
	localparam logic signed [SHIFT_W-1:0] SAT_LO = -SHIFT_W'(32767);

	function automatic logic signed [AXIS_W-1:0] qmul(
		input logic signed [AXIS_W-1:0] a,
		input logic signed [AXIS_W-1:0] b
	);
		logic signed [2*AXIS_W-1:0] p;
		p = a * b;
		return AXIS_W'(p >>> (AXIS_W - 1));
	endfunction

	function automatic logic signed [AXIS_W-1:0] clamp(input logic signed [PROD_W-1:0] p);
		logic signed [SHIFT_W-1:0] s;
		s = SHIFT_W'(p >>> SCALE_W);
		if (s > SAT_HI) begin
			s = SAT_HI;
		end else if (s < SAT_LO) begin
			s = SAT_LO;
		end
		return AXIS_W'(s);
	endfunction

	logic [SCALE_W-1:0] axis_scale_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	logic signed [AXIS_W-1:0] sp, cp, sy, cy, sr, cr;

	logic signed [AXIS_W-1:0] srsp_s2, crsp_s2, crsy_s2, crcy_s2, srsy_s2, srcy_s2;
	logic signed [AXIS_W-1:0] rz_s2, crcp_s2, cpcy_s2, cpsy_s2, sp_s2, sy_s2, cy_s2;

	logic signed [AXIS_W-1:0] srspcy_s3, srspsy_s3, crspcy_s3, crspsy_s3;
	logic signed [AXIS_W-1:0] crsy_s3, crcy_s3, srsy_s3, srcy_s3;
	logic signed [AXIS_W-1:0] rz_s3, crcp_s3, cpcy_s3, cpsy_s3, sp_s3;

	logic signed [SUM_W-1:0] pre [NUM_AXES];
	logic signed [PROD_W-1:0] prod_s4 [NUM_AXES];
	axes_t axes_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_scale_q <= AXIS_SCALE_RESET;
		end else if (cfg_wr_en) begin
			axis_scale_q <= cfg_wr_data;
		end
	end

	// advance a stage when it is empty or the next one advances
	assign en_s5 = !v_s5 || axes.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign angles.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= angles.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
		.clk(clk), .en(en_s1), .angle(angles.data.pitch_angle), .sin_val(sp), .cos_val(cp)
	);
	e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
		.clk(clk), .en(en_s1), .angle(angles.data.yaw_angle), .sin_val(sy), .cos_val(cy)
	);
	e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
		.clk(clk), .en(en_s1), .angle(angles.data.roll_angle), .sin_val(sr), .cos_val(cr)
	);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			srsp_s2 <= qmul(sr, sp);
			crsp_s2 <= qmul(cr, sp);
			crsy_s2 <= qmul(cr, sy);
			crcy_s2 <= qmul(cr, cy);
			srsy_s2 <= qmul(sr, sy);
			srcy_s2 <= qmul(cy, sr);
			rz_s2 <= qmul(-sr, cp);
			crcp_s2 <= qmul(cr, cp);
			cpcy_s2 <= qmul(cp, cy);
			cpsy_s2 <= qmul(cp, sy);
			sp_s2 <= sp;
			sy_s2 <= sy;
			cy_s2 <= cy;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			srspcy_s3 <= qmul(srsp_s2, cy_s2);
			srspsy_s3 <= qmul(srsp_s2, sy_s2);
			crspcy_s3 <= qmul(crsp_s2, cy_s2);
			crspsy_s3 <= qmul(crsp_s2, sy_s2);
			crsy_s3 <= crsy_s2;
			crcy_s3 <= crcy_s2;
			srsy_s3 <= srsy_s2;
			srcy_s3 <= srcy_s2;
			rz_s3 <= rz_s2;
			crcp_s3 <= crcp_s2;
			cpcy_s3 <= cpcy_s2;
			cpsy_s3 <= cpsy_s2;
			sp_s3 <= sp_s2;
		end
	end

	always_comb begin
		pre[0] = SUM_W'(crsy_s3) - SUM_W'(srspcy_s3);
		pre[1] = -(SUM_W'(srspsy_s3) + SUM_W'(crcy_s3));
		pre[2] = -SUM_W'(rz_s3);
		pre[3] = -(SUM_W'(crspcy_s3) + SUM_W'(srsy_s3));
		pre[4] = SUM_W'(srcy_s3) - SUM_W'(crspsy_s3);
		pre[5] = SUM_W'(crcp_s3);
		pre[6] = SUM_W'(cpcy_s3);
		pre[7] = SUM_W'(cpsy_s3);
		pre[8] = SUM_W'(sp_s3);
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				prod_s4[i] <= pre[i] * $signed({1'b0, axis_scale_q});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			axes_s5.right_axis_x <= clamp(prod_s4[0]);
			axes_s5.right_axis_y <= clamp(prod_s4[1]);
			axes_s5.right_axis_z <= clamp(prod_s4[2]);
			axes_s5.up_axis_x <= clamp(prod_s4[3]);
			axes_s5.up_axis_y <= clamp(prod_s4[4]);
			axes_s5.up_axis_z <= clamp(prod_s4[5]);
			axes_s5.forward_axis_x <= clamp(prod_s4[6]);
			axes_s5.forward_axis_y <= clamp(prod_s4[7]);
			axes_s5.forward_axis_z <= clamp(prod_s4[8]);
		end
	end

	assign axes.valid = v_s5;
	assign axes.data = axes_s5;

	`ASSERT_NEXT(a_accept_enters, clk, arst_n, angles.valid && angles.ready, v_s1, "accepted transaction missing from first stage")
	`ASSERT_NEXT(a_s4_reaches_out, clk, arst_n, v_s4 && en_s5, axes.valid, "fourth stage item lost on way to output")
	`ASSERT_IMPLY(a_stall_only_full, clk, arst_n, !angles.ready, v_s1 && v_s2 && v_s3 && v_s4 && axes.valid && !axes.ready, "input stalled with a free stage")
	`ASSERT_IMPLY(a_clamp_range, clk, arst_n, axes.valid, axes.data.forward_axis_z != -16'sd32768 && axes.data.right_axis_x != -16'sd32768, "result outside clamp range")

endmodule

`default_nettype wire

### tb/euler_axes_checker.sv
`default_nettype none

module euler_axes_checker #(
	parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic [e2r_pkg::SCALE_W-1:0] cfg_wr_data,
	input  wire logic angles_valid,
	input  wire logic angles_ready,
	input  wire e2r_pkg::angles_t angles_data,
	input  wire logic axes_valid,
	input  wire logic axes_ready,
	input  wire e2r_pkg::axes_t axes_data,
	output int pending,
	output int mismatches
);
	import e2r_pkg::*;

	localparam int QUARTER = 1 << (ANGLE_BITS - 2);
	localparam int LUT_MASK = (1 << ANGLE_BITS) - 1;
	localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
	localparam longint unsigned ONE_Q60 = 64'h1000000000000000;
	localparam int REPORT_LIMIT = 10;
	localparam int AXIS_FIELDS = 9;

	longint quarter_lut [0:QUARTER];
	longint sine_lut [0:LUT_MASK];
	logic [SCALE_W-1:0] scale;
	axes_t expected_axes [$];
	int error_total = 0;

	assign mismatches = error_total;

	function automatic longint unsigned q60_mul(input longint unsigned a,
			input longint unsigned b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	function automatic longint quarter_wave(input int m);
		longint unsigned mm;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned dv;
		mm = m;
		x = q60_mul(PI_Q60, mm << (61 - ANGLE_BITS));
		x2 = q60_mul(x, x);
		term = x;
		pos = x;
		neg = 0;
		for (int n = 1; n <= 13; n++) begin
			dv = 2 * n * (2 * n + 1);
			term = q60_mul(term, x2) / dv;
			if (n % 2 == 1)
				neg += term;
			else
				pos += term;
		end
		pos = (pos > neg) ? pos - neg : 64'd0;
		if (pos > ONE_Q60)
			pos = ONE_Q60;
		return longint'((64'd32767 * (pos >> 20) + (64'd1 << 39)) >> 40);
	endfunction

	initial begin : fill_sine_lut
		int q;
		int r;
		longint v;
		for (int m = 0; m <= QUARTER; m++)
			quarter_lut[m] = quarter_wave(m);
		for (int k = 0; k <= LUT_MASK; k++) begin
			q = (k >> (ANGLE_BITS - 2)) & 3;
			r = k & (QUARTER - 1);
			v = q[0] ? quarter_lut[QUARTER - r] : quarter_lut[r];
			sine_lut[k] = q[1] ? -v : v;
		end
	end

	function automatic longint product_q15(input longint a, input longint b);
		return (a * b) >>> 15;
	endfunction

	function automatic logic signed [AXIS_W-1:0] scale_clamp(input longint v,
			input logic [SCALE_W-1:0] s);
		longint sl;
		longint r;
		sl = s;
		r = (v * sl) >>> 16;
		if (r > 32767)
			r = 32767;
		if (r < -32767)
			r = -32767;
		return r[AXIS_W-1:0];
	endfunction

	function automatic axes_t predict_axes(input angles_t a, input logic [SCALE_W-1:0] s);
		int kp;
		int ky;
		int kr;
		longint sp, cp, sy, cy, sr, cr, srsp, crsp;
		longint rx, ry, rz, ux, uy, uz;
		axes_t e;
		kp = a.pitch_angle >> (ANGLE_W - ANGLE_BITS);
		ky = a.yaw_angle >> (ANGLE_W - ANGLE_BITS);
		kr = a.roll_angle >> (ANGLE_W - ANGLE_BITS);
		sp = sine_lut[kp];
		cp = sine_lut[(kp + QUARTER) & LUT_MASK];
		sy = sine_lut[ky];
		cy = sine_lut[(ky + QUARTER) & LUT_MASK];
		sr = sine_lut[kr];
		cr = sine_lut[(kr + QUARTER) & LUT_MASK];
		srsp = product_q15(sr, sp);
		crsp = product_q15(cr, sp);
		rx = product_q15(srsp, cy) - product_q15(cr, sy);
		ry = product_q15(srsp, sy) + product_q15(cr, cy);
		rz = product_q15(-sr, cp);
		ux = -(product_q15(crsp, cy) + product_q15(sr, sy));
		uy = product_q15(cy, sr) - product_q15(crsp, sy);
		uz = product_q15(cr, cp);
		e.right_axis_x = scale_clamp(-rx, s);
		e.right_axis_y = scale_clamp(-ry, s);
		e.right_axis_z = scale_clamp(-rz, s);
		e.up_axis_x = scale_clamp(ux, s);
		e.up_axis_y = scale_clamp(uy, s);
		e.up_axis_z = scale_clamp(uz, s);
		e.forward_axis_x = scale_clamp(product_q15(cp, cy), s);
		e.forward_axis_y = scale_clamp(product_q15(cp, sy), s);
		e.forward_axis_z = scale_clamp(sp, s);
		return e;
	endfunction

	function automatic string field_name(input int i);
		case (i)
			0: return "right_axis_x";
			1: return "right_axis_y";
			2: return "right_axis_z";
			3: return "up_axis_x";
			4: return "up_axis_y";
			5: return "up_axis_z";
			6: return "forward_axis_x";
			7: return "forward_axis_y";
			default: return "forward_axis_z";
		endcase
	endfunction

	task automatic compare_axes(input axes_t got);
		axes_t want;
		logic signed [AXIS_W-1:0] w;
		logic signed [AXIS_W-1:0] g;
		if (expected_axes.size() == 0) begin
			error_total++;
			if (error_total <= REPORT_LIMIT)
				$display("%0t: unexpected axes transaction %h", $realtime, got);
			return;
		end
		want = expected_axes.pop_front();
		for (int i = 0; i < AXIS_FIELDS; i++) begin
			w = want[(AXIS_FIELDS - 1 - i) * AXIS_W +: AXIS_W];
			g = got[(AXIS_FIELDS - 1 - i) * AXIS_W +: AXIS_W];
			if (w !== g) begin
				error_total++;
				if (error_total <= REPORT_LIMIT)
					$display("%0t: %s expected %0d, got %0d", $realtime,
						field_name(i), w, g);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_axes.delete();
			scale <= AXIS_SCALE_RESET;
			pending <= 0;
		end else begin
			if (cfg_wr_en)
				scale <= cfg_wr_data;
			if (axes_valid && axes_ready)
				compare_axes(axes_data);
			if (angles_valid && angles_ready)
				expected_axes.push_back(predict_axes(angles_data, scale));
			pending <= expected_axes.size();
		end
	end

endmodule

`default_nettype wire

### tb/euler_to_rotation_axes_tb.sv
`default_nettype none

module euler_to_rotation_axes_tb;
	import e2r_pkg::*;

	localparam int HOLD_OFF_CYCLES = 48;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [SCALE_W-1:0] cfg_wr_data;
	int pending;
	int mismatches;
	int hold_off_requests = 0;
	int hold_off_done = 0;
	angles_t angle_queue [$];

	e2r_stream_if #(.data_t(angles_t)) angles_ch ();
	e2r_stream_if #(.data_t(axes_t)) axes_ch ();

	euler_to_rotation_axes #(
		.ANGLE_BITS(ANGLE_BITS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.angles(angles_ch),
		.axes(axes_ch)
	);

	euler_axes_checker #(
		.ANGLE_BITS(ANGLE_BITS_DEF)
	) axes_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.angles_valid(angles_ch.valid),
		.angles_ready(angles_ch.ready),
		.angles_data(angles_ch.data),
		.axes_valid(axes_ch.valid),
		.axes_ready(axes_ch.ready),
		.axes_data(axes_ch.data),
		.pending(pending),
		.mismatches(mismatches)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [ANGLE_W-1:0] random_angle();
		case ($urandom_range(0, 5))
			0: return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 64) - 32);
			1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			2: return 16'(1 << $urandom_range(0, 15));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic queue_angles(input logic [ANGLE_W-1:0] p, input logic [ANGLE_W-1:0] y,
			input logic [ANGLE_W-1:0] r);
		angles_t a;
		a.pitch_angle = p;
		a.yaw_angle = y;
		a.roll_angle = r;
		angle_queue.push_back(a);
	endtask

	task automatic queue_directed();
		queue_angles(16'h0000, 16'h0000, 16'h0000);
		queue_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_angles(16'h4000, 16'h0000, 16'h0000);
		queue_angles(16'h0000, 16'h4000, 16'h0000);
		queue_angles(16'h0000, 16'h0000, 16'h4000);
		queue_angles(16'h8000, 16'h8000, 16'h8000);
		queue_angles(16'hC000, 16'hC000, 16'hC000);
		queue_angles(16'h3FFF, 16'h4000, 16'h4001);
		queue_angles(16'h2000, 16'h6000, 16'hA000);
		queue_angles(16'hE000, 16'h2000, 16'h1000);
		queue_angles(16'h000F, 16'hFFF0, 16'h8000);
		queue_angles(16'hAAAA, 16'h5555, 16'hCCCC);
		queue_angles(16'h5555, 16'hAAAA, 16'h3333);
		queue_angles(16'h7FFF, 16'hBFFF, 16'hFFF0);
		queue_angles(16'h1234, 16'hABCD, 16'hF00D);
		queue_angles(16'h4000, 16'h4000, 16'h4000);
		queue_angles(16'hC000, 16'h4000, 16'h8000);
		queue_angles(16'h0010, 16'h0020, 16'h0030);
	endtask

	task automatic queue_random(input int count);
		repeat (count)
			queue_angles(random_angle(), random_angle(), random_angle());
	endtask

	task automatic drive_queued(input int max_gap);
		int burst;
		int gap;
		burst = $urandom_range(1, 24);
		while (angle_queue.size() != 0) begin
			angles_ch.valid <= 1'b1;
			angles_ch.data <= angle_queue.pop_front();
			do @(posedge clk); while (!angles_ch.ready);
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				gap = $urandom_range(0, max_gap);
				if (gap != 0 && angle_queue.size() != 0) begin
					angles_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		angles_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_scale(input logic [SCALE_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : axes_receiver
		int mode;
		int span;
		int hold;
		mode = 0;
		span = 0;
		hold = 0;
		axes_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_done != hold_off_requests) begin
				hold = HOLD_OFF_CYCLES;
				hold_off_done++;
			end
			if (hold > 0) begin
				hold--;
				axes_ch.ready <= 1'b0;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(16, 80);
				end
				span--;
				case (mode)
					0: axes_ch.ready <= 1'b1;
					1: axes_ch.ready <= 1'($urandom_range(0, 1));
					2: axes_ch.ready <= ($urandom_range(0, 3) == 0);
					default: axes_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		angles_ch.valid <= 1'b0;
		angles_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_directed();
		drive_queued(6);
		queue_random(120);
		drive_queued(6);
		wait_idle();

		write_scale(16'hFFFF);
		queue_directed();
		queue_random(90);
		drive_queued(6);
		wait_idle();

		write_scale(16'h0000);
		queue_random(60);
		drive_queued(4);
		wait_idle();

		// fill the pipeline behind a stalled receiver
		write_scale(16'h8000);
		queue_random(90);
		hold_off_requests++;
		drive_queued(0);
		wait_idle();

		write_scale(16'h0001);
		queue_random(40);
		drive_queued(6);
		wait_idle();

		write_scale(16'($urandom_range(2, 65534)));
		queue_random(90);
		drive_queued(3);
		wait_idle();

		write_scale(AXIS_SCALE_RESET);
		queue_random(60);
		hold_off_requests++;
		drive_queued(0);
		wait_idle();

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
